FILE: src/plb_pkg.sv
package plb_pkg;

    localparam int TOT_W   = 48;
    localparam int PRICE_W = 33;
    localparam int QTY_W   = 32;
    localparam int RANK_W  = 13;
    localparam int LIDX_W  = 12;
    localparam int TICK_W  = 10;
    localparam int LOWER_W = 32;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_QRY = 2'd2;

    localparam logic CFG_LOWER = 1'b0;
    localparam logic CFG_TICK  = 1'b1;

    localparam logic [TICK_W-1:0] TICK_RESET = 10'd100;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TOT,
        S_WALK,
        S_INSW,
        S_UNL,
        S_SETNEXT,
        S_SETPREV,
        S_QRY,
        S_QHOP,
        S_DONE
    } t_state;

endpackage

FILE: src/price_level_book_core.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: level_index, quantity, rank
//                                               tuser: opcode, is_buy
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: best_bid, best_ask, total, ranked
//                                               tuser: error_flag
// cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// An add or subtract that keeps the level linked state passes S_TOT only; linking in at
// the head adds S_SETPREV if an old head exists; deeper insertion walks S_WALK level by
// level, then S_INSW and S_SETPREV as needed; unlinking runs S_UNL, then S_SETNEXT and
// S_SETPREV as needed. A rank query loops S_QRY and S_QHOP per hop; an ignored beat goes
// straight to S_DONE. All walks run through the single read port of the link memory, one
// entry per hop. Reset: a clearing pass zeroes all 2 << clog2(NUM_LEVELS) level totals
// (8192 at 4096 levels); no beat is accepted until it ends. Stalls: a finished result is
// held in the output register while the next input beat is taken and worked on.
module price_level_book_core
    import plb_pkg::*;
#(
    parameter int NUM_LEVELS = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [63:0]         s_axis_tdata,  // level_index[11:0], quantity[43:12], rank[56:44]
    input  logic [2:0]          s_axis_tuser,  // opcode[1:0], is_buy[2]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [151:0]        m_axis_tdata,  // bid[32:0], ask[65:33], total[113:66],
                                               // ranked[146:114]
    output logic [0:0]          m_axis_tuser,  // error_flag[0]
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int IW    = $clog2(NUM_LEVELS);
    localparam int LW    = IW + 1;          // link pointer, top bit marks null
    localparam int AW    = IW + 1;          // side bit above the level index
    localparam int DEPTH = 2 << IW;
    localparam logic [LW-1:0] LNULL = LW'(1) << IW;

    t_state r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [LOWER_W-1:0]  r_lower;
    logic [TICK_W-1:0]   r_tick;
    logic [1:0]          r_op, n_op;
    logic                r_buy, n_buy;
    logic [IW-1:0]       r_idx, n_idx;
    logic [QTY_W-1:0]    r_q, n_q;
    logic [RANK_W-1:0]   r_rank, n_rank, r_cnt, n_cnt;
    logic [LW-1:0]       r_head_b, n_head_b, r_head_a, n_head_a;
    logic [LW-1:0]       r_cur, n_cur, r_p, n_p, r_n, n_n;
    logic [LW-1:0]       r_fix_addr, n_fix_addr, r_fix_prev, n_fix_prev;
    logic [TOT_W-1:0]    r_tot_after, n_tot_after;
    logic                r_err, n_err;
    logic                r_out_valid, n_out_valid;
    logic [151:0]        r_out_data, n_out_data;
    logic                r_out_err, n_out_err;

    logic                tot_we;
    logic [AW-1:0]       tot_waddr, tot_raddr;
    logic [TOT_W-1:0]    tot_wdata, tot_rdata;
    logic                lk_we;
    logic [AW-1:0]       lk_waddr, lk_raddr;
    logic [2*LW-1:0]     lk_wdata, lk_rdata;

    logic [1:0]          s_op;
    logic                s_buy;
    logic [LIDX_W-1:0]   s_lidx;
    logic                s_idx_ok;
    logic                accept, load;
    logic [LW-1:0]       head, rd_prev, rd_next, idx_ptr;
    logic [TOT_W:0]      sum;
    logic                err_now, beyond;
    logic [TOT_W-1:0]    new_tot;
    logic [IW+9:0]       mul_b, mul_a, mul_r;
    logic [PRICE_W-1:0]  price_b, price_a, price_r;

    assign s_op     = s_axis_tuser[1:0];
    assign s_buy    = s_axis_tuser[2];
    assign s_lidx   = s_axis_tdata[11:0];
    assign s_idx_ok = 32'(s_lidx) < NUM_LEVELS;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    assign head    = r_buy ? r_head_b : r_head_a;
    assign rd_prev = lk_rdata[2*LW-1:LW];
    assign rd_next = lk_rdata[LW-1:0];
    assign idx_ptr = {1'b0, r_idx};
    assign sum     = {1'b0, tot_rdata} + (TOT_W+1)'(r_q);
    assign err_now = (r_op == OP_ADD) ? sum[TOT_W] : ((TOT_W)'(r_q) > tot_rdata);
    assign new_tot = (r_op == OP_ADD) ? sum[TOT_W-1:0] : tot_rdata - (TOT_W)'(r_q);
    assign beyond  = !rd_next[IW] && (r_buy ? (rd_next[IW-1:0] > r_idx)
                                            : (rd_next[IW-1:0] < r_idx));

    // Prices of both heads and of the query cursor
    assign mul_b   = (IW+TICK_W)'(r_head_b[IW-1:0]) * (IW+TICK_W)'(r_tick);
    assign mul_a   = (IW+TICK_W)'(r_head_a[IW-1:0]) * (IW+TICK_W)'(r_tick);
    assign mul_r   = (IW+TICK_W)'(r_cur[IW-1:0]) * (IW+TICK_W)'(r_tick);
    assign price_b = r_head_b[IW] ? '0 : PRICE_W'(r_lower) + PRICE_W'(mul_b);
    assign price_a = r_head_a[IW] ? '0 : PRICE_W'(r_lower) + PRICE_W'(mul_a);
    assign price_r = r_cur[IW]    ? '0 : PRICE_W'(r_lower) + PRICE_W'(mul_r);

    plb_ram #(.WIDTH(TOT_W), .DEPTH(DEPTH)) u_tot_ram (
        .i_clk   (i_clk),
        .i_we    (tot_we),
        .i_waddr (tot_waddr),
        .i_wdata (tot_wdata),
        .i_raddr (tot_raddr),
        .o_rdata (tot_rdata)
    );

    plb_ram #(.WIDTH(2*LW), .DEPTH(DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_buy       = r_buy;
        n_idx       = r_idx;
        n_q         = r_q;
        n_rank      = r_rank;
        n_cnt       = r_cnt;
        n_head_b    = r_head_b;
        n_head_a    = r_head_a;
        n_cur       = r_cur;
        n_p         = r_p;
        n_n         = r_n;
        n_fix_addr  = r_fix_addr;
        n_fix_prev  = r_fix_prev;
        n_tot_after = r_tot_after;
        n_err       = r_err;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_err   = r_out_err;
        load        = 1'b0;
        tot_we      = 1'b0;
        tot_waddr   = {r_buy, r_idx};
        tot_wdata   = new_tot;
        tot_raddr   = {s_buy, IW'(s_lidx)};
        lk_we       = 1'b0;
        lk_waddr    = {r_buy, r_idx};
        lk_wdata    = '0;
        lk_raddr    = {r_buy, r_cur[IW-1:0]};

        case (r_state)
            S_CLEAR: begin
                // zero one total a cycle
                tot_we    = 1'b1;
                tot_waddr = r_clr;
                tot_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op        = s_op;
                    n_buy       = s_buy;
                    n_idx       = IW'(s_lidx);
                    n_q         = s_axis_tdata[43:12];
                    n_rank      = s_axis_tdata[56:44];
                    n_cnt       = RANK_W'(1);
                    n_cur       = LNULL;
                    n_tot_after = '0;
                    n_err       = 1'b0;
                    if ((s_op == OP_ADD || s_op == OP_SUB) && s_idx_ok) begin
                        n_state = S_TOT;
                    end else if (s_op == OP_QRY) begin
                        n_cur   = s_buy ? r_head_b : r_head_a;
                        n_state = S_QRY;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TOT: begin
                n_err       = err_now;
                n_tot_after = err_now ? tot_rdata : new_tot;
                n_state     = S_DONE;
                if (!err_now) begin
                    tot_we = 1'b1;
                    if (r_op == OP_ADD && tot_rdata == '0 && r_q != '0) begin
                        if (head[IW] || (r_buy ? (r_idx > head[IW-1:0])
                                               : (r_idx < head[IW-1:0]))) begin
                            // link in as new head
                            lk_we    = 1'b1;
                            lk_wdata = {LNULL, head};
                            if (r_buy) n_head_b = idx_ptr;
                            else       n_head_a = idx_ptr;
                            if (!head[IW]) begin
                                lk_raddr   = {r_buy, head[IW-1:0]};
                                n_fix_addr = head;
                                n_fix_prev = idx_ptr;
                                n_state    = S_SETPREV;
                            end
                        end else begin
                            n_cur    = head;
                            lk_raddr = {r_buy, head[IW-1:0]};
                            n_state  = S_WALK;
                        end
                    end else if (r_op == OP_SUB && tot_rdata != '0
                                 && tot_rdata == (TOT_W)'(r_q)) begin
                        lk_raddr = {r_buy, r_idx};
                        n_state  = S_UNL;
                    end
                end
            end
            S_WALK: begin
                if (beyond) begin
                    n_cur    = rd_next;
                    lk_raddr = {r_buy, rd_next[IW-1:0]};
                end else begin
                    lk_we    = 1'b1;
                    lk_waddr = {r_buy, r_cur[IW-1:0]};
                    lk_wdata = {rd_prev, idx_ptr};
                    n_n      = rd_next;
                    n_state  = S_INSW;
                end
            end
            S_INSW: begin
                lk_we    = 1'b1;
                lk_wdata = {r_cur, r_n};
                n_state  = S_DONE;
                if (!r_n[IW]) begin
                    lk_raddr   = {r_buy, r_n[IW-1:0]};
                    n_fix_addr = r_n;
                    n_fix_prev = idx_ptr;
                    n_state    = S_SETPREV;
                end
            end
            S_UNL: begin
                n_p     = rd_prev;
                n_n     = rd_next;
                n_state = S_DONE;
                if (!rd_prev[IW]) begin
                    lk_raddr = {r_buy, rd_prev[IW-1:0]};
                    n_state  = S_SETNEXT;
                end else begin
                    if (r_buy) n_head_b = rd_next;
                    else       n_head_a = rd_next;
                    if (!rd_next[IW]) begin
                        lk_raddr   = {r_buy, rd_next[IW-1:0]};
                        n_fix_addr = rd_next;
                        n_fix_prev = rd_prev;
                        n_state    = S_SETPREV;
                    end
                end
            end
            S_SETNEXT: begin
                lk_we    = 1'b1;
                lk_waddr = {r_buy, r_p[IW-1:0]};
                lk_wdata = {rd_prev, r_n};
                n_state  = S_DONE;
                if (!r_n[IW]) begin
                    lk_raddr   = {r_buy, r_n[IW-1:0]};
                    n_fix_addr = r_n;
                    n_fix_prev = r_p;
                    n_state    = S_SETPREV;
                end
            end
            S_SETPREV: begin
                lk_we    = 1'b1;
                lk_waddr = {r_buy, r_fix_addr[IW-1:0]};
                lk_wdata = {r_fix_prev, rd_next};
                n_state  = S_DONE;
            end
            S_QRY: begin
                if (r_cnt < r_rank && !r_cur[IW]) begin
                    n_state = S_QHOP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QHOP: begin
                n_cur   = rd_next;
                n_cnt   = r_cnt + RANK_W'(1);
                n_state = S_QRY;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load        = 1'b1;
                    n_out_valid = 1'b1;
                    // ranked price only for a query; the insertion walk also moves the cursor
                    n_out_data  = {5'd0, ((r_op == OP_QRY) ? price_r : {PRICE_W{1'b0}}),
                                   r_tot_after, price_a, price_b};
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_lower     <= '0;
            r_tick      <= TICK_RESET;
            r_head_b    <= LNULL;
            r_head_a    <= LNULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head_b    <= n_head_b;
            r_head_a    <= n_head_a;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_LOWER) r_lower <= i_cfg_data;
                else if (i_cfg_index == CFG_TICK) r_tick <= i_cfg_data[TICK_W-1:0];
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_buy       <= n_buy;
        r_idx       <= n_idx;
        r_q         <= n_q;
        r_rank      <= n_rank;
        r_cnt       <= n_cnt;
        r_cur       <= n_cur;
        r_p         <= n_p;
        r_n         <= n_n;
        r_fix_addr  <= n_fix_addr;
        r_fix_prev  <= n_fix_prev;
        r_tot_after <= n_tot_after;
        r_err       <= n_err;
        r_out_data  <= n_out_data;
        r_out_err   <= n_out_err;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_err;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_valid || m_axis_tready))
        else $error("result overwrote a pending beat");

    a_tot_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tot_we |-> (r_state == S_CLEAR || r_state == S_TOT))
        else $error("total written outside update");

    a_link_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lk_we && (r_state == S_INSW || r_state == S_SETNEXT)) |=>
            (r_state == S_DONE || r_state == S_SETPREV))
        else $error("link update sequence broken");

endmodule

FILE: src/plb_ram.sv
module plb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

// Price-level book: drive add, subtract and rank-query beats through the input
// stream, predict every result beat from a private copy of both sides of the
// book, and compare field by field. Config writes happen only while the book is
// drained. The output side stalls in random bursts plus one long hold-off.
module testbench;
    import plb_pkg::*;

    localparam logic [1:0] OP_NONE   = 2'd3;   // unused opcode, must change nothing
    localparam int         LEVELS    = 4096;
    localparam int         NO_LEVEL  = -1;
    localparam int         IDLE_LIMIT = 40000; // clearing pass and deepest walk fit well inside
    localparam int         RAND_ITEMS = 1700;
    localparam int         QUIET_FROM = 1450;  // no idling from here on

    typedef struct packed {
        logic [PRICE_W-1:0] bid;
        logic [PRICE_W-1:0] ask;
        logic [TOT_W-1:0]   total;
        logic [PRICE_W-1:0] ranked;
        logic               err;
    } t_book_result;

    // Scoreboard: private book copy plus the queue of expected result beats.
    class t_book_scoreboard;
        bit [TOT_W-1:0]   bid_tot [LEVELS];
        bit [TOT_W-1:0]   ask_tot [LEVELS];
        bit [LOWER_W-1:0] lower;
        bit [TICK_W-1:0]  tick;
        t_book_result     expected_q [$];
        int               errors;
        int               checked;
        int               refused;
        int               queries;

        function new();
            lower = '0;
            tick  = TICK_RESET;
        endfunction

        function bit [PRICE_W-1:0] price_of(int idx);
            bit [63:0] p;
            if (idx == NO_LEVEL) return '0;
            p = 64'(lower) + 64'(idx) * 64'(tick);
            return p[PRICE_W-1:0];
        endfunction

        // k-th non-empty level in book order (bids high to low, asks low to high)
        function int nth_level(bit buy, int k);
            int seen;
            seen = 0;
            if (k < 1) k = 1;
            for (int n = 0; n < LEVELS; n++) begin
                int i;
                i = buy ? LEVELS - 1 - n : n;
                if ((buy ? bid_tot[i] : ask_tot[i]) != 0) begin
                    seen++;
                    if (seen == k) return i;
                end
            end
            return NO_LEVEL;
        endfunction

        function void write_reg(bit idx, bit [31:0] data);
            if (idx == CFG_LOWER) lower = data;
            else tick = data[TICK_W-1:0];
        endfunction

        function void note(bit [1:0] op, bit buy, bit [LIDX_W-1:0] idx,
                           bit [QTY_W-1:0] q, bit [RANK_W-1:0] rank);
            t_book_result r;
            bit [TOT_W-1:0] t;
            r = '0;
            t = buy ? bid_tot[idx] : ask_tot[idx];
            if (op == OP_ADD || op == OP_SUB) begin
                if (op == OP_ADD && 48'(q) > {TOT_W{1'b1}} - t) r.err = 1'b1;
                else if (op == OP_SUB && 48'(q) > t) r.err = 1'b1;
                else if (op == OP_ADD) t = t + 48'(q);
                else t = t - 48'(q);
                if (buy) bid_tot[idx] = t;
                else ask_tot[idx] = t;
                r.total = t;
                refused += r.err;
            end else if (op == OP_QRY) begin
                r.ranked = price_of(nth_level(buy, int'(rank)));
                queries++;
            end
            r.bid = price_of(nth_level(1'b1, 1));
            r.ask = price_of(nth_level(1'b0, 1));
            expected_q = {expected_q, r};
        endfunction

        function void check(logic [151:0] d, logic e);
            t_book_result x;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: tdata=%h", d);
                errors++;
                return;
            end
            x = expected_q.pop_front();
            checked++;
            if (d[32:0] !== x.bid) begin
                $error("best_bid_price: expected %0d, got %0d", x.bid, d[32:0]);
                errors++;
            end
            if (d[65:33] !== x.ask) begin
                $error("best_ask_price: expected %0d, got %0d", x.ask, d[65:33]);
                errors++;
            end
            if (d[113:66] !== x.total) begin
                $error("level_total_after: expected %0d, got %0d", x.total, d[113:66]);
                errors++;
            end
            if (d[146:114] !== x.ranked) begin
                $error("ranked_price: expected %0d, got %0d", x.ranked, d[146:114]);
                errors++;
            end
            if (e !== x.err) begin
                $error("error_flag: expected %0d, got %0d", x.err, e);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;   // level_index[11:0], quantity[43:12], rank[56:44]
    logic [2:0]   s_axis_tuser = '0;   // opcode[1:0], is_buy[2]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [151:0] m_axis_tdata;        // bid[32:0], ask[65:33], total[113:66], ranked[146:114]
    logic [0:0]   m_axis_tuser;        // error_flag[0]
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_index = 1'b0;
    logic [31:0]  i_cfg_data = '0;

    t_book_scoreboard book = new();
    int  sent = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  long_hold_done = 1'b0;
    int  level_pool [48];

    price_level_book_core #(.NUM_LEVELS(LEVELS)) i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Monitor and watchdog: sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                book.note(s_axis_tuser[1:0], s_axis_tuser[2], s_axis_tdata[11:0],
                          s_axis_tdata[43:12], s_axis_tdata[56:44]);
            if (m_axis_tvalid && m_axis_tready)
                book.check(m_axis_tdata, m_axis_tuser[0]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("testbench: done, errors");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random stall bursts, one long hold-off to back the book up.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && sent >= 300) begin
                long_hold_done = 1'b1;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 12) - 1;
                m_axis_tready <= 1'b0;
            end else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_beat(bit [1:0] op, bit buy, bit [LIDX_W-1:0] idx,
                             bit [QTY_W-1:0] q, bit [RANK_W-1:0] rank);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, rank, q, idx};
        s_axis_tuser  <= {buy, op};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent++;
    endtask

    // Drain the book, then let it settle before touching a register.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (book.expected_q.size() == 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(bit idx, bit [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_beats();
        send_beat(OP_QRY,  1'b1, 12'd0,    32'd0,          13'd0);    // empty book
        send_beat(OP_ADD,  1'b1, 12'd0,    32'hFFFF_FFFF,  13'd0);
        send_beat(OP_ADD,  1'b1, 12'hFFF,  32'd1,          13'd0);    // new best bid at head
        send_beat(OP_ADD,  1'b1, 12'd2047, 32'd500,        13'd0);    // middle insertion
        send_beat(OP_ADD,  1'b0, 12'hFFF,  32'd7,          13'd0);
        send_beat(OP_ADD,  1'b0, 12'd0,    32'd9,          13'd0);    // new best ask
        send_beat(OP_ADD,  1'b0, 12'd1365, 32'hAAAA_5555,  13'd0);
        send_beat(OP_ADD,  1'b1, 12'd100,  32'd0,          13'd0);    // zero add, no link
        send_beat(OP_ADD,  1'b1, 12'd2047, 32'd1,          13'd0);    // add to a live level
        send_beat(OP_QRY,  1'b1, 12'd0,    32'd0,          13'd1);
        send_beat(OP_QRY,  1'b1, 12'd0,    32'd0,          13'd2);
        send_beat(OP_QRY,  1'b0, 12'd0,    32'd0,          13'd3);
        send_beat(OP_QRY,  1'b0, 12'd0,    32'd0,          13'd4);    // past the tail
        send_beat(OP_QRY,  1'b1, 12'd0,    32'd0,          13'd4096);
        send_beat(OP_QRY,  1'b0, 12'd0,    32'd0,          13'h1FFF);
        send_beat(OP_SUB,  1'b1, 12'd2047, 32'd502,        13'd0);    // underflow refused
        send_beat(OP_SUB,  1'b1, 12'd300,  32'd1,          13'd0);    // underflow on empty level
        send_beat(OP_SUB,  1'b1, 12'd2047, 32'd0,          13'd0);    // zero subtract
        send_beat(OP_SUB,  1'b1, 12'hFFF,  32'd1,          13'd0);    // unlink the head
        send_beat(OP_SUB,  1'b1, 12'd0,    32'hFFFF_FFFF,  13'd0);    // unlink the tail
        send_beat(OP_SUB,  1'b0, 12'd1365, 32'hAAAA_5555,  13'd0);    // unlink the middle
        send_beat(OP_NONE, 1'b1, 12'hFFF,  32'hFFFF_FFFF,  13'h1FFF); // unused opcode
        send_beat(OP_QRY,  1'b1, 12'd0,    32'd0,          13'd1);
    endtask

    task automatic random_beats(int count);
        bit [1:0]        op;
        bit              buy;
        bit [LIDX_W-1:0] idx;
        bit [QTY_W-1:0]  q;
        bit [RANK_W-1:0] rank;
        bit [TOT_W-1:0]  t;
        int              pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            op   = pick < 45 ? OP_ADD : pick < 80 ? OP_SUB : pick < 97 ? OP_QRY : OP_NONE;
            buy  = 1'($urandom_range(0, 1));
            // keep the lists short so walks stay cheap; rarely hit any level
            idx  = $urandom_range(0, 19) == 0 ? LIDX_W'($urandom_range(0, LEVELS - 1))
                                              : LIDX_W'(level_pool[$urandom_range(0, 47)]);
            t    = buy ? book.bid_tot[idx] : book.ask_tot[idx];
            q    = $urandom;
            if (op == OP_SUB) begin
                pick = $urandom_range(0, 9);
                if (pick < 4 && t <= 48'hFFFF_FFFF) q = t[31:0];          // empty the level
                else if (pick < 8 && t != 0)
                    q = t <= 48'hFFFF_FFFF ? $urandom_range(0, t[31:0]) : $urandom;
            end
            rank = $urandom_range(0, 9) == 0 ? RANK_W'($urandom_range(0, 13'h1FFF))
                                             : RANK_W'($urandom_range(0, 40));
            send_beat(op, buy, idx, q, rank);
            quiet = sent >= QUIET_FROM;
        end
    endtask

    initial begin
        bit [31:0] lowers [4];
        bit [9:0]  ticks  [4];
        lowers = '{32'd0, 32'hFFFF_FFFF, 32'd1_000_000, $urandom};
        ticks  = '{10'd1, 10'd1000, 10'd10, 10'($urandom_range(1, 1000))};
        foreach (level_pool[i]) level_pool[i] = $urandom_range(0, LEVELS - 1);
        level_pool[0] = 0;
        level_pool[1] = LEVELS - 1;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_beats();   // runs at the reset config
        for (int p = 0; p < 4; p++) begin
            drain();
            write_reg(CFG_LOWER, lowers[p]);
            write_reg(CFG_TICK, {22'd0, ticks[p]});
            random_beats(RAND_ITEMS / 4);
        end
        s_axis_tvalid <= 1'b0;
        wait (book.expected_q.size() == 0);
        repeat (50) @(posedge i_clk);

        $display("covered %0d beats: %0d results checked, %0d queries, %0d refused updates",
                 sent, book.checked, book.queries, book.refused);
        $display("config swept over lower price and tick extremes in 4 phases");
        if (book.errors == 0 && book.expected_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

FILE: sim.f
src/plb_pkg.sv
src/plb_ram.sv
src/price_level_book_core.sv
verif/testbench.sv
